@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold on the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/slcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// slcfd_pkg
// Types, codes and the CRC byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
package slcfd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;
   localparam int CODE_W = 3;
   localparam int CAP_W  = 6;

   localparam logic [15:0]       CRC_INIT     = 16'hFFFF;
   localparam logic [15:0]       CRC_POLY     = 16'h1021;
   localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hAA;
   localparam logic [CAP_W-1:0]  CAP_RESET    = 6'd32;

   // Configuration register indexes.
   localparam logic CSR_SYNC_BYTE     = 1'b0;
   localparam logic CSR_DEST_CAPACITY = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      ST_OK    = 3'd0,
      ST_TRUNC = 3'd1,
      ST_SYNC  = 3'd2,
      ST_LEN   = 3'd3,
      ST_CRC   = 3'd4,
      ST_SMALL = 3'd5
   } status_code_type;

   // One finished frame, handed from the front to the back.
   typedef struct packed {
      status_code_type    code;
      logic [BYTE_W-1:0]  frame_type;
      logic [LEN_W-1:0]   length;
   } frame_cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_LOAD,
      BK_STATUS
   } back_state_type;

   // CRC-16, MSB first, one byte per call.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/slcfd_ram.sv @@
// ----------------------------------------------------------------------------
// slcfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slcfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/slcfd_front.sv @@
// ----------------------------------------------------------------------------
// slcfd_front
// Byte parser: tracks frame position, runs the CRC, stores payload bytes and
// queues one command per buffer.
// ----------------------------------------------------------------------------
module slcfd_front #(
   parameter int MAX_PAYLOAD = 32,
   localparam int PosW  = $clog2(MAX_PAYLOAD + 5),
   localparam int LenW  = $clog2(MAX_PAYLOAD + 1),
   localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [slcfd_pkg::BYTE_W-1:0]            req_data_byte,
   input  logic                                    req_end_of_buffer,
   input  logic [slcfd_pkg::BYTE_W-1:0]            sync_byte,
   input  logic [slcfd_pkg::CAP_W-1:0]             dest_capacity,
   input  logic                                    drain_busy,
   input  logic                                    cmd_full,
   output logic                                    cmd_push,
   output slcfd_pkg::frame_cmd_type                cmd_data,
   output logic                                    ram_wr_en,
   output logic [AddrW-1:0]                        ram_wr_addr,
   output logic [slcfd_pkg::BYTE_W-1:0]            ram_wr_data
);
   import slcfd_pkg::*;

   logic [PosW-1:0]   pos_ff, pos_in;
   logic [15:0]       crc_ff, crc_in;
   logic [LenW-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] crc_hi_ff, crc_hi_in;
   logic              skip_ff, skip_in;

   logic              accept;
   logic              in_payload;
   logic [PosW-1:0]   payload_end;
   logic [15:0]       crc_next;

   assign payload_end = PosW'(len_ff) + PosW'(3);
   assign in_payload  = !skip_ff && (pos_ff >= PosW'(3)) && (pos_ff < payload_end);
   // Payload bytes wait while the back may still read the store.
   assign req_ready   = !cmd_full && !(in_payload && drain_busy);
   assign accept      = req_valid && req_ready;
   assign crc_next    = crc16_update(crc_ff, req_data_byte);

   assign ram_wr_addr = AddrW'(pos_ff - PosW'(3));
   assign ram_wr_data = req_data_byte;

   always_comb begin
      logic            done;
      status_code_type code;
      done      = 1'b0;
      code      = ST_OK;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      len_in    = len_ff;
      kind_in   = kind_ff;
      crc_hi_in = crc_hi_ff;
      skip_in   = skip_ff;
      cmd_push  = 1'b0;
      cmd_data  = '{code: ST_OK, frame_type: '0, length: '0};
      ram_wr_en = 1'b0;

      if (accept) begin
         if (skip_ff) begin
            if (req_end_of_buffer) begin
               skip_in = 1'b0;
            end
         end else begin
            if (pos_ff == PosW'(0)) begin
               if (req_end_of_buffer) begin
                  done = 1'b1;
                  code = ST_TRUNC;
               end else if (req_data_byte != sync_byte) begin
                  done = 1'b1;
                  code = ST_SYNC;
               end else begin
                  crc_in = crc_next;
               end
            end else if (pos_ff == PosW'(1)) begin
               if (req_data_byte > BYTE_W'(MAX_PAYLOAD)) begin
                  done = 1'b1;
                  code = ST_LEN;
               end else begin
                  len_in = LenW'(req_data_byte);
                  crc_in = crc_next;
               end
            end else if (pos_ff == PosW'(2)) begin
               kind_in = req_data_byte;
               crc_in  = crc_next;
            end else if (in_payload) begin
               ram_wr_en = 1'b1;
               crc_in    = crc_next;
            end else if (pos_ff == payload_end) begin
               crc_hi_in = req_data_byte;
            end else begin
               done = 1'b1;
               if ({crc_hi_ff, req_data_byte} != crc_ff) begin
                  code = ST_CRC;
               end else if ((len_ff != '0) && (dest_capacity < CAP_W'(len_ff))) begin
                  code = ST_SMALL;
               end else begin
                  code = ST_OK;
               end
            end

            // A frame cut short by the end flag reports truncated.
            if (!done && req_end_of_buffer) begin
               done = 1'b1;
               code = ST_TRUNC;
            end

            if (done) begin
               cmd_push      = 1'b1;
               cmd_data.code = code;
               if (code == ST_OK) begin
                  cmd_data.frame_type = kind_ff;
                  cmd_data.length     = LEN_W'(len_ff);
               end
               pos_in    = '0;
               crc_in    = CRC_INIT;
               len_in    = '0;
               kind_in   = '0;
               crc_hi_in = '0;
               skip_in   = !req_end_of_buffer;
            end else begin
               pos_in = pos_ff + PosW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= CRC_INIT;
         len_ff    <= '0;
         kind_ff   <= '0;
         crc_hi_ff <= '0;
         skip_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         len_ff    <= len_in;
         kind_ff   <= kind_in;
         crc_hi_ff <= crc_hi_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

@@ rtl/slcfd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// slcfd_cmd_fifo
// Two-entry queue of frame commands between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slcfd_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  slcfd_pkg::frame_cmd_type push_data,
   input  logic                     pop,
   output slcfd_pkg::frame_cmd_type pop_data,
   output logic                     not_empty,
   output logic                     full
);
   import slcfd_pkg::*;

   frame_cmd_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !full)
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, not_empty)

endmodule

@@ rtl/slcfd_back.sv @@
// ----------------------------------------------------------------------------
// slcfd_back
// Result sequencer: drains stored payload bytes of a good frame, then sends
// the frame status, through one output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slcfd_back #(
   parameter int MAX_PAYLOAD = 32,
   localparam int LenW  = $clog2(MAX_PAYLOAD + 1),
   localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  slcfd_pkg::frame_cmd_type       cmd_data,
   output logic                           cmd_pop,
   output logic                           ram_rd_en,
   output logic [AddrW-1:0]               ram_rd_addr,
   input  logic [slcfd_pkg::BYTE_W-1:0]   ram_rd_data,
   output logic                           busy,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_is_status,
   output logic [slcfd_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic [slcfd_pkg::BYTE_W-1:0]   rsp_frame_type,
   output logic [slcfd_pkg::LEN_W-1:0]    rsp_payload_length,
   output logic [slcfd_pkg::CODE_W-1:0]   rsp_status_code,
   output logic                           rsp_last
);
   import slcfd_pkg::*;

   back_state_type    state_ff, state_in;
   frame_cmd_type     cmd_ff;
   logic [LenW-1:0]   idx_ff, idx_in;
   logic [LenW-1:0]   idx_inc;
   logic              out_free;
   logic              load_byte;
   logic              load_status;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              is_status_ff;
   logic [BYTE_W-1:0] payload_byte_ff;
   logic [BYTE_W-1:0] frame_type_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [CODE_W-1:0] code_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_inc  = idx_ff + LenW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if ((cmd_data.code == ST_OK) && (cmd_data.length != '0)) begin
                  state_in = BK_READ;
               end else begin
                  state_in = BK_STATUS;
               end
            end
         end
         BK_READ: begin
            state_in = BK_LOAD;
         end
         BK_LOAD: begin
            if (out_free) begin
               state_in = (idx_inc == LenW'(cmd_ff.length)) ? BK_STATUS : BK_READ;
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      cmd_pop     = 1'b0;
      ram_rd_en   = 1'b0;
      load_byte   = 1'b0;
      load_status = 1'b0;
      case (state_ff)
         BK_IDLE:   cmd_pop     = cmd_valid;
         BK_READ:   ram_rd_en   = 1'b1;
         BK_LOAD:   load_byte   = out_free;
         BK_STATUS: load_status = out_free;
         default:   cmd_pop     = 1'b0;
      endcase
   end

   assign busy        = (state_ff != BK_IDLE);
   assign ram_rd_addr = AddrW'(idx_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd_pop) begin
         idx_in = '0;
      end else if (load_byte) begin
         idx_in = idx_inc;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_byte || load_status) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (load_byte) begin
         is_status_ff    <= 1'b0;
         payload_byte_ff <= ram_rd_data;
         frame_type_ff   <= '0;
         length_ff       <= '0;
         code_ff         <= ST_OK;
      end else if (load_status) begin
         is_status_ff    <= 1'b1;
         payload_byte_ff <= '0;
         frame_type_ff   <= cmd_ff.frame_type;
         length_ff       <= cmd_ff.length;
         code_ff         <= cmd_ff.code;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_status      = is_status_ff;
   assign rsp_payload_byte   = payload_byte_ff;
   assign rsp_frame_type     = frame_type_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_status_code    = code_ff;
   assign rsp_last           = is_status_ff;

   `ASSERT_IMPLIES(a_drain_in_range, clock, reset, (state_ff == BK_LOAD),
      (idx_ff < LenW'(cmd_ff.length)))

endmodule

@@ rtl/sync_length_crc_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// sync_length_crc_frame_decoder_core
// Deframer for sync / length / type / payload / CRC-16 frames, one byte a word.
// ----------------------------------------------------------------------------
// The block takes one byte of a receive buffer per input word and gives one
// status word per buffer; a good frame's payload bytes come out first, each
// as its own word, and the status word (with last set) follows. The front
// parser takes a byte every cycle, with two exceptions: a payload byte is held
// off while the back still drains an earlier frame out of the shared payload
// RAM or has one waiting in the queue, and any byte waits while the two-entry
// command queue is full. The back side takes a command off the queue, then for
// each payload word reads the RAM through its registered read port into the
// output register, then loads the status word; each load waits while the
// output register still holds a word that the consumer has not taken. There
// is no clearing pass after reset: the payload store is always written by a
// frame before it is read.
`include "assert_macros.svh"

module sync_length_crc_frame_decoder_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [slcfd_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                          req_end_of_buffer,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_status,
   output logic [slcfd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic [slcfd_pkg::BYTE_W-1:0]  rsp_frame_type,
   output logic [slcfd_pkg::LEN_W-1:0]   rsp_payload_length,
   output logic [slcfd_pkg::CODE_W-1:0]  rsp_status_code,
   output logic                          rsp_last,

   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [slcfd_pkg::BYTE_W-1:0]  csr_wdata
);
   import slcfd_pkg::*;

   localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Configuration registers.
   logic [BYTE_W-1:0] sync_byte_ff, sync_byte_in;
   logic [CAP_W-1:0]  dest_capacity_ff, dest_capacity_in;

   always_comb begin
      sync_byte_in     = sync_byte_ff;
      dest_capacity_in = dest_capacity_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_BYTE:     sync_byte_in     = csr_wdata;
            CSR_DEST_CAPACITY: dest_capacity_in = csr_wdata[CAP_W-1:0];
            default:           sync_byte_in     = sync_byte_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff     <= SYNC_RESET;
         dest_capacity_ff <= CAP_RESET;
      end else begin
         sync_byte_ff     <= sync_byte_in;
         dest_capacity_ff <= dest_capacity_in;
      end
   end

   // Front to queue, queue to back.
   logic              cmd_push;
   frame_cmd_type     cmd_push_data;
   logic              cmd_pop;
   frame_cmd_type     cmd_pop_data;
   logic              cmd_not_empty;
   logic              cmd_full;
   logic              back_busy;
   logic              drain_busy;

   // Payload store ports.
   logic              ram_wr_en;
   logic [AddrW-1:0]  ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AddrW-1:0]  ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // The back may still read the store whenever it is active or has a frame
   // queued; the front writes new payload only once both are clear.
   assign drain_busy = back_busy || cmd_not_empty;

   slcfd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .sync_byte         (sync_byte_ff),
      .dest_capacity     (dest_capacity_ff),
      .drain_busy        (drain_busy),
      .cmd_full          (cmd_full),
      .cmd_push          (cmd_push),
      .cmd_data          (cmd_push_data),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data)
   );

   slcfd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .not_empty (cmd_not_empty),
      .full      (cmd_full)
   );

   slcfd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   slcfd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_not_empty),
      .cmd_data           (cmd_pop_data),
      .cmd_pop            (cmd_pop),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .busy               (back_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_status      (rsp_is_status),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status_code    (rsp_status_code),
      .rsp_last           (rsp_last)
   );

   // A payload write must never land while the back can still read the store.
   `ASSERT_IMPLIES(a_no_write_during_drain, clock, reset, ram_wr_en, !drain_busy)

endmodule

@@ dv/deframe_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the byte, result and register ports of the deframer, predicts every
// result word from the accepted bytes and compares in order.
// ----------------------------------------------------------------------------
module deframe_checker #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [slcfd_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                          req_end_of_buffer,

   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_is_status,
   input  logic [slcfd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   input  logic [slcfd_pkg::BYTE_W-1:0]  rsp_frame_type,
   input  logic [slcfd_pkg::LEN_W-1:0]   rsp_payload_length,
   input  logic [slcfd_pkg::CODE_W-1:0]  rsp_status_code,
   input  logic                          rsp_last,

   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [slcfd_pkg::BYTE_W-1:0]  csr_wdata,

   output int                            mismatch_count,
   output int                            words_pending
);

   import slcfd_pkg::*;

   typedef struct packed {
      logic                is_status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   frame_type;
      logic [LEN_W-1:0]    payload_length;
      status_code_type     status_code;
      logic                last;
   } result_word_type;

   result_word_type   expected_words[$];

   // Register copies.
   logic [BYTE_W-1:0] sync_cfg;
   logic [CAP_W-1:0]  capacity_cfg;

   // Parser state.
   int                position;
   logic [15:0]       crc_acc;
   logic [7:0]        length_seen;
   logic [7:0]        kind_seen;
   logic [7:0]        crc_msb;
   logic              skipping;
   logic [7:0]        payload_mem [MAX_PAYLOAD];

   function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                            input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   task automatic clear_frame();
      position    = 0;
      crc_acc     = 16'hFFFF;
      length_seen = '0;
      kind_seen   = '0;
      crc_msb     = '0;
      skipping    = 1'b0;
   endtask

   // Queues the status word; without the end flag the rest of the buffer is skipped.
   task automatic post_status(input status_code_type code, input logic end_flag);
      result_word_type w;
      w = '0;
      w.is_status   = 1'b1;
      w.status_code = code;
      w.last        = 1'b1;
      if (code == ST_OK) begin
         w.frame_type     = kind_seen;
         w.payload_length = length_seen[LEN_W-1:0];
      end
      expected_words.push_back(w);
      clear_frame();
      skipping = !end_flag;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic end_flag);
      result_word_type w;
      logic [15:0]     rx_crc;
      if (skipping) begin
         if (end_flag) begin
            clear_frame();
         end
         return;
      end
      if (position == 0) begin
         if (end_flag) begin
            post_status(ST_TRUNC, 1'b1);
            return;
         end
         if (b != sync_cfg) begin
            post_status(ST_SYNC, 1'b0);
            return;
         end
         crc_acc = crc_step(crc_acc, b);
      end else if (position == 1) begin
         if (b > MAX_PAYLOAD) begin
            post_status(ST_LEN, end_flag);
            return;
         end
         length_seen = b;
         crc_acc     = crc_step(crc_acc, b);
      end else if (position == 2) begin
         kind_seen = b;
         crc_acc   = crc_step(crc_acc, b);
      end else if (position < 3 + int'(length_seen)) begin
         payload_mem[position - 3] = b;
         crc_acc = crc_step(crc_acc, b);
      end else if (position == 3 + int'(length_seen)) begin
         crc_msb = b;
      end else begin
         rx_crc = {crc_msb, b};
         if (rx_crc != crc_acc) begin
            post_status(ST_CRC, end_flag);
         end else if (length_seen != 0 && capacity_cfg < length_seen) begin
            post_status(ST_SMALL, end_flag);
         end else begin
            for (int i = 0; i < int'(length_seen); i++) begin
               w = '0;
               w.payload_byte = payload_mem[i];
               expected_words.push_back(w);
            end
            post_status(ST_OK, end_flag);
         end
         return;
      end
      if (end_flag) begin
         post_status(ST_TRUNC, 1'b1);
         return;
      end
      position++;
   endtask

   task automatic flag_error(input string msg);
      if (mismatch_count < 10) begin
         $display("%0t ns: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
   end

   always @(posedge clock) begin
      result_word_type got;
      result_word_type want;
      if (reset) begin
         sync_cfg     = SYNC_RESET;
         capacity_cfg = CAP_RESET;
         clear_frame();
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_SYNC_BYTE) begin
               sync_cfg = csr_wdata;
            end else begin
               capacity_cfg = csr_wdata[CAP_W-1:0];
            end
         end
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_end_of_buffer);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_is_status, rsp_payload_byte, rsp_frame_type,
                    rsp_payload_length, status_code_type'(rsp_status_code), rsp_last};
            if (expected_words.size() == 0) begin
               flag_error($sformatf(
                  "unexpected word st=%0b byte=%02h type=%02h len=%0d code=%0d last=%0b",
                  got.is_status, got.payload_byte, got.frame_type,
                  got.payload_length, got.status_code, got.last));
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  flag_error($sformatf({"mismatch expected st=%0b byte=%02h type=%02h",
                     " len=%0d code=%0d last=%0b, got st=%0b byte=%02h type=%02h",
                     " len=%0d code=%0d last=%0b"},
                     want.is_status, want.payload_byte, want.frame_type,
                     want.payload_length, want.status_code, want.last,
                     got.is_status, got.payload_byte, got.frame_type,
                     got.payload_length, got.status_code, got.last));
               end
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sync / length / CRC-16 frame deframer.
// ----------------------------------------------------------------------------
// Receive buffers are built here, one byte per input word, and pushed through
// the byte channel with random gaps while the result channel stalls at random.
// A checker module beside the block predicts every result word and counts the
// mismatches; this module only makes traffic, changes the registers between
// phases and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   import slcfd_pkg::*;

   // Bytes of random buffers sent per phase, at the least.
   localparam int PHASE_BYTES = 100;
   // Quiet cycles after the last expected word; covers a full drain of the back.
   localparam int SETTLE_CYCLES = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_end_of_buffer = 1'b0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_is_status;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic [BYTE_W-1:0]   rsp_frame_type;
   logic [LEN_W-1:0]    rsp_payload_length;
   logic [CODE_W-1:0]   rsp_status_code;
   logic                rsp_last;

   logic                csr_wr_en = 1'b0;
   logic                csr_index = 1'b0;
   logic [BYTE_W-1:0]   csr_wdata = '0;

   int                  mismatch_count;
   int                  words_pending;

   // Current sync byte as the generator sees it, and the idling switch.
   logic [BYTE_W-1:0]   cur_sync = SYNC_RESET;
   logic                idling = 1'b1;

   // The buffer under construction; its last byte carries the end flag.
   logic [7:0]          buf_bytes[$];

   sync_length_crc_frame_decoder_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_status      (rsp_is_status),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status_code    (rsp_status_code),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   deframe_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_status      (rsp_is_status),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status_code    (rsp_status_code),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .words_pending      (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs; a correct run takes far less.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side. After every accepted word a stall is drawn, zero when idling is
   // off; ready stays low until the drawn stall has run down, counting only while a
   // word is on offer, so the stall lands on payload words and status words alike.
   logic rsp_took = 1'b0;
   int   stall_left = 0;

   always @(posedge clock) begin
      rsp_took <= rsp_valid && rsp_ready;
   end

   always @(negedge clock) begin
      if (rsp_took) begin
         stall_left = idling ? $urandom_range(0, 5) : 0;
      end else if (stall_left > 0 && rsp_valid) begin
         stall_left--;
      end
      rsp_ready <= (stall_left == 0);
   end

   // CRC-16 used to build well-formed frames (init FFFF, poly 1021, MSB first).
   function automatic logic [15:0] stim_crc(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // Starts a new buffer with the frame header: sync, length and type.
   task automatic begin_frame(input int len, input logic [7:0] kind);
      buf_bytes.delete();
      buf_bytes.push_back(cur_sync);
      buf_bytes.push_back(8'(len));
      buf_bytes.push_back(kind);
   endtask

   // Appends the big-endian CRC over everything in the buffer so far.
   task automatic close_frame();
      logic [15:0] crc;
      crc = 16'hFFFF;
      foreach (buf_bytes[i]) begin
         crc = stim_crc(crc, buf_bytes[i]);
      end
      buf_bytes.push_back(crc[15:8]);
      buf_bytes.push_back(crc[7:0]);
   endtask

   task automatic add_junk(input int count);
      repeat (count) begin
         buf_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // One word on the byte channel. Valid is lowered only when a gap is drawn,
   // so back-to-back words keep it high without a glitch.
   task automatic send_byte(input logic [7:0] value, input logic end_flag);
      int gap;
      gap = idling ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= value;
      req_end_of_buffer <= end_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_buffer();
      foreach (buf_bytes[i]) begin
         send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
      end
   endtask

   // Every buffer ends with its end flag, so once the last expected word is
   // out and the settle time has passed, the block sits at the start of a
   // buffer with nothing in flight.
   task automatic end_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int          sent;
      int          len;
      int          pick;
      logic [5:0]  cap;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buffers at the reset settings.
      // End flag on the very first byte: truncated even though it is not sync.
      buf_bytes = '{8'h5A};
      send_buffer();
      // Wrong first byte: bad sync at once, then the tail up to the flag is skipped.
      buf_bytes = '{8'h00, 8'hFF};
      send_buffer();
      // Oversized length on the buffer's last byte still reports bad length.
      buf_bytes = '{cur_sync, 8'hFF};
      send_buffer();
      // Valid length but the buffer ends right there: truncated.
      buf_bytes = '{cur_sync, 8'd1};
      send_buffer();
      // Empty payload, status and end flag on the same byte.
      begin_frame(0, 8'hFF);
      close_frame();
      send_buffer();
      // One payload byte with the CRC broken in its low byte.
      begin_frame(1, 8'h00);
      buf_bytes.push_back(8'h00);
      close_frame();
      buf_bytes[buf_bytes.size() - 1] ^= 8'h80;
      send_buffer();
      // Good frame followed by a trailing byte that carries the end flag.
      begin_frame(2, 8'h5A);
      buf_bytes.push_back(8'hFF);
      buf_bytes.push_back(8'h00);
      close_frame();
      buf_bytes.push_back(8'h3C);
      send_buffer();
      end_phase();

      // Random phases, each under its own register settings. The fourth phase
      // runs with no idling on either side.
      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: begin
               cur_sync = 8'h00;
               cap      = 6'd32;
               idling   = 1'b1;
            end
            2: begin
               cur_sync = 8'hFF;
               cap      = 6'd0;
               idling   = 1'b1;
            end
            3: begin
               cur_sync = 8'($urandom_range(0, 255));
               cap      = 6'($urandom_range(1, 31));
               idling   = 1'b1;
            end
            4: begin
               cur_sync = SYNC_RESET;
               cap      = 6'd32;
               idling   = 1'b0;
            end
            default: begin
               cur_sync = 8'($urandom_range(0, 255));
               cap      = 6'd5;
               idling   = 1'b1;
            end
         endcase
         write_reg(CSR_SYNC_BYTE, cur_sync);
         write_reg(CSR_DEST_CAPACITY, {2'b00, cap});

         sent = 0;
         while (sent < PHASE_BYTES) begin
            // Mostly short payloads, now and then a long one or the largest.
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               len = 32;
            end else if (pick == 1) begin
               len = $urandom_range(9, 31);
            end else begin
               len = $urandom_range(0, 8);
            end

            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               begin_frame(len, 8'($urandom_range(0, 255)));
               add_junk(len);
               close_frame();
               if (pick < 12) begin
                  // Complete frame with bytes after it that are skipped.
                  add_junk($urandom_range(1, 3));
               end else if (pick >= 50 && pick < 58) begin
                  // Flip one bit in one of the two CRC bytes.
                  buf_bytes[buf_bytes.size() - 1 - $urandom_range(0, 1)] ^=
                     8'h01 << $urandom_range(0, 7);
               end else if (pick >= 58) begin
                  // End flag somewhere before the frame completes.
                  len = $urandom_range(1, buf_bytes.size() - 1);
                  while (buf_bytes.size() > len) void'(buf_bytes.pop_back());
               end
            end else if (pick < 78) begin
               buf_bytes.delete();
               buf_bytes.push_back(cur_sync ^ 8'($urandom_range(1, 255)));
               add_junk($urandom_range(0, 3));
            end else if (pick < 86) begin
               buf_bytes.delete();
               buf_bytes.push_back(cur_sync);
               buf_bytes.push_back(8'($urandom_range(33, 255)));
               add_junk($urandom_range(0, 3));
            end else if (pick < 94) begin
               buf_bytes.delete();
               add_junk($urandom_range(1, 6));
            end else begin
               buf_bytes.delete();
               add_junk(1);
            end
            send_buffer();
            sent += buf_bytes.size();
         end
         end_phase();
      end

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/slcfd_pkg.sv
rtl/slcfd_ram.sv
rtl/slcfd_front.sv
rtl/slcfd_cmd_fifo.sv
rtl/slcfd_back.sv
rtl/sync_length_crc_frame_decoder_core.sv
dv/deframe_checker.sv
dv/tb_top.sv
